[sv/dcp_pkg.sv]
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared widths, status codes and pipeline tag types for the distance
// constraint projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package dcp_pkg;

    localparam int AXES        = 3;
    localparam int COORD_W     = 32;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int MAG_W       = DIFF_W;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int LEN_W       = SQ_W / 2;
    localparam int MASS_W      = 24;
    localparam int WSUM_W      = MASS_W + 1;
    localparam int REST_W      = 31;
    localparam int RATIO_W     = 10;
    localparam int RATIO_SHIFT = 8;
    localparam int THR_W       = REST_W + RATIO_W;
    localparam int ERR_W       = LEN_W + 1;
    localparam int PROD_W      = MAG_W + LEN_W;
    localparam int WNUM_W      = MAG_W + WSUM_W;
    localparam int POS_W       = COORD_W + 4;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 10'd320;

    typedef enum logic [1:0] {
        STATUS_APPLIED   = 2'd0,
        STATUS_CUT       = 2'd1,
        STATUS_ZERO_LEN  = 2'd2,
        STATUS_ZERO_MASS = 2'd3
    } status_t;

    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] p1;
        logic [AXES-1:0][COORD_W-1:0] p2;
        logic [MASS_W-1:0]            w1;
        logic [MASS_W-1:0]            w2;
        logic                         m1;
        logic                         m2;
        logic [REST_W-1:0]            rest;
    } joint_t;

    // Sideband through the square root pipe
    typedef struct packed {
        joint_t                     j;
        logic [AXES-1:0]            d_neg;
        logic [AXES-1:0][MAG_W-1:0] mag;
        logic [THR_W-1:0]           thr;
    } sqrt_tag_t;

    // Sideband through both divider pipes
    typedef struct packed {
        joint_t            j;
        status_t           status;
        logic [REST_W-1:0] new_rest;
        logic [AXES-1:0]   neg;
        logic [WSUM_W-1:0] ws;
    } corr_tag_t;

endpackage

`default_nettype wire

[sv/distance_constraint_projection.sv]
// ----------------------------------------------------------------------------
// distance_constraint_projection: one joint in, one corrected joint out
// Pipeline stages: 3 prep, 33 square root, 2 error, 33 length divide,
// 1 mass product, 33 mass divide, 1 output. Throughput one per cycle;
// all stages advance together whenever the output register can move.
// Reset empties the pipe and sets break_ratio to 1.25.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_constraint_projection (
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [9:0]          cfg_data,

    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic signed [31:0]  first_x,
    input  wire logic signed [31:0]  first_y,
    input  wire logic signed [31:0]  first_z,
    input  wire logic signed [31:0]  second_x,
    input  wire logic signed [31:0]  second_y,
    input  wire logic signed [31:0]  second_z,
    input  wire logic [23:0]         first_inv_mass,
    input  wire logic [23:0]         second_inv_mass,
    input  wire logic                first_moving,
    input  wire logic                second_moving,
    input  wire logic [30:0]         rest_length,

    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic signed [31:0]       new_first_x,
    output logic signed [31:0]       new_first_y,
    output logic signed [31:0]       new_first_z,
    output logic signed [31:0]       new_second_x,
    output logic signed [31:0]       new_second_y,
    output logic signed [31:0]       new_second_z,
    output logic [30:0]              new_rest_length,
    output logic [1:0]               status
);

    localparam int AXES    = dcp_pkg::AXES;
    localparam int COORD_W = dcp_pkg::COORD_W;
    localparam int DIFF_W  = dcp_pkg::DIFF_W;
    localparam int MAG_W   = dcp_pkg::MAG_W;
    localparam int SQ_W    = dcp_pkg::SQ_W;
    localparam int LEN_W   = dcp_pkg::LEN_W;
    localparam int WSUM_W  = dcp_pkg::WSUM_W;
    localparam int REST_W  = dcp_pkg::REST_W;
    localparam int RATIO_W = dcp_pkg::RATIO_W;
    localparam int THR_W   = dcp_pkg::THR_W;
    localparam int ERR_W   = dcp_pkg::ERR_W;
    localparam int PROD_W  = dcp_pkg::PROD_W;
    localparam int WNUM_W  = dcp_pkg::WNUM_W;
    localparam int POS_W   = dcp_pkg::POS_W;
    localparam int SQ_TAG_W   = $bits(dcp_pkg::sqrt_tag_t);
    localparam int CORR_TAG_W = $bits(dcp_pkg::corr_tag_t);

    localparam logic signed [POS_W-1:0] POS_MAX = POS_W'(2147483647);
    localparam logic signed [POS_W-1:0] POS_MIN = POS_W'(32'sh80000000);

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [POS_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v > POS_MAX)
            r = POS_MAX[COORD_W-1:0];
        else if (v < POS_MIN)
            r = POS_MIN[COORD_W-1:0];
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

    logic en;
    logic [RATIO_W-1:0] break_ratio_reg;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid || !out_stall;
    assign in_stall  = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            break_ratio_reg <= dcp_pkg::RATIO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            break_ratio_reg <= cfg_data;
        end
    end

    // ---------------- stage A: differences, rest threshold
    dcp_pkg::joint_t               a_joint_next, a_joint_reg;
    logic [AXES-1:0]               a_neg_next, a_neg_reg;
    logic [AXES-1:0][MAG_W-1:0]    a_mag_next, a_mag_reg;
    logic [THR_W-1:0]              a_thr_next, a_thr_reg;
    logic                          a_valid_reg;
    logic [AXES-1:0][DIFF_W-1:0]   a_diff;

    always_comb
    begin
        a_joint_next.p1[0] = first_x;
        a_joint_next.p1[1] = first_y;
        a_joint_next.p1[2] = first_z;
        a_joint_next.p2[0] = second_x;
        a_joint_next.p2[1] = second_y;
        a_joint_next.p2[2] = second_z;
        a_joint_next.w1    = first_inv_mass;
        a_joint_next.w2    = second_inv_mass;
        a_joint_next.m1    = first_moving;
        a_joint_next.m2    = second_moving;
        a_joint_next.rest  = rest_length;
        for (int i = 0; i < AXES; i++)
        begin
            a_diff[i] = {a_joint_next.p2[i][COORD_W-1], a_joint_next.p2[i]}
                      - {a_joint_next.p1[i][COORD_W-1], a_joint_next.p1[i]};
            a_neg_next[i] = a_diff[i][DIFF_W-1];
            a_mag_next[i] = a_neg_next[i] ? (~a_diff[i] + 1'b1) : a_diff[i];
        end
        a_thr_next = THR_W'(rest_length) * THR_W'(break_ratio_reg);
    end

    // ---------------- stage B: squares
    logic [AXES-1:0][SQ_W-1:0] b_sq_next, b_sq_reg;
    dcp_pkg::sqrt_tag_t        b_tag_next, b_tag_reg;
    logic                      b_valid_reg;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            b_sq_next[i] = SQ_W'(a_mag_reg[i]) * SQ_W'(a_mag_reg[i]);
        end
        b_tag_next.j     = a_joint_reg;
        b_tag_next.d_neg = a_neg_reg;
        b_tag_next.mag   = a_mag_reg;
        b_tag_next.thr   = a_thr_reg;
    end

    // ---------------- stage C: sum of squares
    logic [SQ_W-1:0]    c_sum_next, c_sum_reg;
    dcp_pkg::sqrt_tag_t c_tag_reg;
    logic               c_valid_reg;

    assign c_sum_next = b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_joint_reg <= a_joint_next;
            a_neg_reg   <= a_neg_next;
            a_mag_reg   <= a_mag_next;
            a_thr_reg   <= a_thr_next;
            b_sq_reg    <= b_sq_next;
            b_tag_reg   <= b_tag_next;
            c_sum_reg   <= c_sum_next;
            c_tag_reg   <= b_tag_reg;
        end
    end

    // ---------------- square root
    logic                  s_valid;
    logic [LEN_W-1:0]      s_len;
    logic [SQ_TAG_W-1:0]   s_tag_bits;
    dcp_pkg::sqrt_tag_t    s_tag;

    dcp_sqrt #(
        .ROOT_W (LEN_W),
        .TAG_W  (SQ_TAG_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid_reg),
        .in_rad    (c_sum_reg),
        .in_tag    (c_tag_reg),
        .out_valid (s_valid),
        .out_root  (s_len),
        .out_tag   (s_tag_bits)
    );

    assign s_tag = s_tag_bits;

    // ---------------- stage D: classify, length error
    dcp_pkg::corr_tag_t          d_tag_next, d_tag_reg;
    logic [MAG_W-1:0]            d_err_next, d_err_reg;
    logic [AXES-1:0][MAG_W-1:0]  d_mag_reg;
    logic [LEN_W-1:0]            d_len_reg;
    logic                        d_valid_reg;
    logic [ERR_W-1:0]            d_err_raw;
    logic [ERR_W-1:0]            d_err_abs;
    logic                        d_err_neg;
    logic [WSUM_W-1:0]           d_ws;

    always_comb
    begin
        d_ws      = WSUM_W'(s_tag.j.w1) + WSUM_W'(s_tag.j.w2);
        d_err_raw = ERR_W'(s_len) - ERR_W'(s_tag.j.rest);
        d_err_neg = d_err_raw[ERR_W-1];
        d_err_abs = d_err_neg ? (~d_err_raw + 1'b1) : d_err_raw;
        d_err_next = d_err_abs[MAG_W-1:0];

        d_tag_next.j  = s_tag.j;
        d_tag_next.ws = d_ws;
        for (int i = 0; i < AXES; i++)
        begin
            d_tag_next.neg[i] = d_err_neg ^ s_tag.d_neg[i];
        end

        if (s_len == '0)
            d_tag_next.status = dcp_pkg::STATUS_ZERO_LEN;
        else if ({s_len, {dcp_pkg::RATIO_SHIFT{1'b0}}} >= s_tag.thr)
            d_tag_next.status = dcp_pkg::STATUS_CUT;
        else if (d_ws == '0)
            d_tag_next.status = dcp_pkg::STATUS_ZERO_MASS;
        else
            d_tag_next.status = dcp_pkg::STATUS_APPLIED;

        if (s_len == '0)
            d_tag_next.new_rest = s_tag.j.rest;
        else if (s_len[LEN_W-1:REST_W] != '0)
            d_tag_next.new_rest = '1;
        else
            d_tag_next.new_rest = s_len[REST_W-1:0];
    end

    // ---------------- stage E: error times axis difference
    logic [AXES-1:0][PROD_W-1:0] e_prod_next, e_prod_reg;
    logic [LEN_W-1:0]            e_len_reg;
    dcp_pkg::corr_tag_t          e_tag_reg;
    logic                        e_valid_reg;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            e_prod_next[i] = PROD_W'(d_err_reg) * PROD_W'(d_mag_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= s_valid;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_tag_reg  <= d_tag_next;
            d_err_reg  <= d_err_next;
            d_mag_reg  <= s_tag.mag;
            d_len_reg  <= s_len;
            e_prod_reg <= e_prod_next;
            e_len_reg  <= d_len_reg;
            e_tag_reg  <= d_tag_reg;
        end
    end

    // ---------------- divide by length
    logic                        t_valid;
    logic [AXES-1:0][MAG_W-1:0]  t_quo;
    logic [CORR_TAG_W-1:0]       t_tag_bits;
    dcp_pkg::corr_tag_t          t_tag;

    dcp_div #(
        .LANES (AXES),
        .DEN_W (LEN_W),
        .Q_W   (MAG_W),
        .TAG_W (CORR_TAG_W)
    ) u_div_len (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e_valid_reg),
        .in_num    (e_prod_reg),
        .in_den    ({AXES{e_len_reg}}),
        .in_tag    (e_tag_reg),
        .out_valid (t_valid),
        .out_quo   (t_quo),
        .out_tag   (t_tag_bits)
    );

    assign t_tag = t_tag_bits;

    // ---------------- stage F: mass products, lanes 0..2 first, 3..5 second
    logic [2*AXES-1:0][WNUM_W-1:0] f_num_next, f_num_reg;
    logic [WSUM_W-1:0]             f_ws_reg;
    dcp_pkg::corr_tag_t            f_tag_reg;
    logic                          f_valid_reg;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            f_num_next[i]        = WNUM_W'(t_quo[i]) * WNUM_W'(t_tag.j.w1);
            f_num_next[AXES + i] = WNUM_W'(t_quo[i]) * WNUM_W'(t_tag.j.w2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= t_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_num_reg <= f_num_next;
            f_ws_reg  <= t_tag.ws;
            f_tag_reg <= t_tag;
        end
    end

    // ---------------- divide by mass sum
    logic                          q_valid;
    logic [2*AXES-1:0][MAG_W-1:0]  q_quo;
    logic [CORR_TAG_W-1:0]         q_tag_bits;
    dcp_pkg::corr_tag_t            q_tag;

    dcp_div #(
        .LANES (2 * AXES),
        .DEN_W (WSUM_W),
        .Q_W   (MAG_W),
        .TAG_W (CORR_TAG_W)
    ) u_div_mass (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid_reg),
        .in_num    (f_num_reg),
        .in_den    ({(2 * AXES){f_ws_reg}}),
        .in_tag    (f_tag_reg),
        .out_valid (q_valid),
        .out_quo   (q_quo),
        .out_tag   (q_tag_bits)
    );

    assign q_tag = q_tag_bits;

    // ---------------- output stage: apply correction, saturate
    logic [AXES-1:0][COORD_W-1:0] o_p1_next, o_p1_reg;
    logic [AXES-1:0][COORD_W-1:0] o_p2_next, o_p2_reg;
    logic [REST_W-1:0]            o_rest_reg;
    dcp_pkg::status_t             o_status_reg;
    logic                         out_valid_reg;
    logic signed [POS_W-1:0]      g_c1 [AXES];
    logic signed [POS_W-1:0]      g_c2 [AXES];
    logic signed [POS_W-1:0]      g_n1 [AXES];
    logic signed [POS_W-1:0]      g_n2 [AXES];

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            g_c1[i] = '0;
            g_c2[i] = '0;
            if (q_tag.status == dcp_pkg::STATUS_APPLIED)
            begin
                if (q_tag.j.m1 && q_tag.j.m2)
                begin
                    g_c1[i] = POS_W'(q_quo[i]);
                    g_c2[i] = POS_W'(q_quo[AXES + i]);
                end
                else if (q_tag.j.m1)
                begin
                    g_c1[i] = POS_W'({q_quo[i], 1'b0});
                end
                else if (q_tag.j.m2)
                begin
                    g_c2[i] = POS_W'({q_quo[AXES + i], 1'b0});
                end
            end
            if (q_tag.neg[i])
            begin
                g_c1[i] = -g_c1[i];
                g_c2[i] = -g_c2[i];
            end
            g_n1[i] = POS_W'(signed'(q_tag.j.p1[i])) + g_c1[i];
            g_n2[i] = POS_W'(signed'(q_tag.j.p2[i])) - g_c2[i];
            o_p1_next[i] = sat_coord(g_n1[i]);
            o_p2_next[i] = sat_coord(g_n2[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_p1_reg     <= o_p1_next;
            o_p2_reg     <= o_p2_next;
            o_rest_reg   <= q_tag.new_rest;
            o_status_reg <= q_tag.status;
        end
    end

    assign out_valid       = out_valid_reg;
    assign new_first_x     = o_p1_reg[0];
    assign new_first_y     = o_p1_reg[1];
    assign new_first_z     = o_p1_reg[2];
    assign new_second_x    = o_p2_reg[0];
    assign new_second_y    = o_p2_reg[1];
    assign new_second_z    = o_p2_reg[2];
    assign new_rest_length = o_rest_reg;
    assign status          = o_status_reg;

    // ---------------- assertions
    // Frozen pipe: nothing leaves the square root while the output is held
    a_sqrt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(s_valid) && $stable(s_len))
        else $error("square root pipe moved during stall");

    // Length divide quotient of lane 0 must fit the pipe width on applied joints
    a_div_len_fit: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && e_tag_reg.status == dcp_pkg::STATUS_APPLIED)
        |-> (e_prod_reg[0][PROD_W-1:MAG_W] < e_len_reg))
        else $error("length divide overflow");

    // Mass divide quotients of lanes 0 and 3 must fit as well
    a_div_mass_fit: assert property (@(posedge clk) disable iff (!rst_n)
        (f_valid_reg && f_tag_reg.status == dcp_pkg::STATUS_APPLIED)
        |-> (f_num_reg[0][WNUM_W-1:MAG_W] < f_ws_reg)
            && (f_num_reg[AXES][WNUM_W-1:MAG_W] < f_ws_reg))
        else $error("mass divide overflow");

    // Zero length keeps the rest length that came in
    a_zero_len_rest: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid_reg && d_tag_reg.status == dcp_pkg::STATUS_ZERO_LEN)
        |-> (d_tag_reg.new_rest == d_tag_reg.j.rest) && (d_len_reg == '0))
        else $error("zero length joint changed rest length");

endmodule

`default_nettype wire

[sv/dcp_div.sv]
// ----------------------------------------------------------------------------
// dcp_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one valid and one sideband tag. Quotient must fit in Q_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module dcp_div #(
    parameter int LANES = 1,
    parameter int DEN_W = dcp_pkg::LEN_W,
    parameter int Q_W   = dcp_pkg::MAG_W,
    parameter int NUM_W = Q_W + DEN_W,
    parameter int TAG_W = 1
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire logic                             in_valid,
    input  wire logic [LANES-1:0][NUM_W-1:0]      in_num,
    input  wire logic [LANES-1:0][DEN_W-1:0]      in_den,
    input  wire logic [TAG_W-1:0]                 in_tag,
    output logic                                  out_valid,
    output logic [LANES-1:0][Q_W-1:0]             out_quo,
    output logic [TAG_W-1:0]                      out_tag
);

    logic                             valid_reg [Q_W];
    logic [LANES-1:0][Q_W-1:0]        lq_reg    [Q_W];
    logic [TAG_W-1:0]                 tag_reg   [Q_W];
    logic [LANES-1:0][DEN_W-1:0]      rem_reg   [Q_W-1];
    logic [LANES-1:0][DEN_W-1:0]      den_reg   [Q_W-1];

    genvar g, l;
    generate
        for (g = 0; g < Q_W; g++) begin : g_step
            logic                        valid_in;
            logic [TAG_W-1:0]            tag_in;
            logic [LANES-1:0][DEN_W-1:0] rem_in;
            logic [LANES-1:0][DEN_W-1:0] den_in;
            logic [LANES-1:0][Q_W-1:0]   lq_in;
            logic [LANES-1:0][DEN_W-1:0] rem_next;
            logic [LANES-1:0][Q_W-1:0]   lq_next;

            if (g == 0) begin : g_first
                assign valid_in = in_valid;
                assign tag_in   = in_tag;
                for (l = 0; l < LANES; l++) begin : g_lane_in
                    assign rem_in[l] = in_num[l][NUM_W-1:Q_W];
                    assign lq_in[l]  = in_num[l][Q_W-1:0];
                    assign den_in[l] = in_den[l];
                end
            end else begin : g_rest
                assign valid_in = valid_reg[g-1];
                assign tag_in   = tag_reg[g-1];
                assign rem_in   = rem_reg[g-1];
                assign lq_in    = lq_reg[g-1];
                assign den_in   = den_reg[g-1];
            end

            for (l = 0; l < LANES; l++) begin : g_lane
                logic [DEN_W:0] trial;
                logic [DEN_W:0] diff;
                logic           ge;
                assign trial       = {rem_in[l], lq_in[l][Q_W-1]};
                assign diff        = trial - {1'b0, den_in[l]};
                assign ge          = trial >= {1'b0, den_in[l]};
                assign rem_next[l] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                assign lq_next[l]  = {lq_in[l][Q_W-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[g] <= valid_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    lq_reg[g]  <= lq_next;
                    tag_reg[g] <= tag_in;
                end
            end

            if (g < Q_W - 1) begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[g] <= rem_next;
                        den_reg[g] <= den_in;
                    end
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[Q_W-1];
    assign out_quo   = lq_reg[Q_W-1];
    assign out_tag   = tag_reg[Q_W-1];

endmodule

`default_nettype wire

[sv/dcp_sqrt.sv]
// ----------------------------------------------------------------------------
// dcp_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage,
// with a sideband tag carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module dcp_sqrt #(
    parameter int ROOT_W = dcp_pkg::LEN_W,
    parameter int RAD_W  = 2 * ROOT_W,
    parameter int TAG_W  = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [RAD_W-1:0]  in_rad,
    input  wire logic [TAG_W-1:0]  in_tag,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      out_root,
    output logic [TAG_W-1:0]       out_tag
);

    localparam int REM_W = ROOT_W + 2;
    localparam int T_W   = REM_W + 2;

    logic              valid_reg [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [TAG_W-1:0]  tag_reg   [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W-1];
    logic [RAD_W-1:0]  rad_reg   [ROOT_W-1];

    genvar g;
    generate
        for (g = 0; g < ROOT_W; g++) begin : g_step
            logic              valid_in;
            logic [TAG_W-1:0]  tag_in;
            logic [REM_W-1:0]  rem_in;
            logic [RAD_W-1:0]  rad_in;
            logic [ROOT_W-1:0] root_in;
            logic [T_W-1:0]    cur;
            logic [T_W-1:0]    trial;
            logic [T_W-1:0]    diff;
            logic              ge;
            logic [REM_W-1:0]  rem_next;
            logic [RAD_W-1:0]  rad_next;
            logic [ROOT_W-1:0] root_next;

            if (g == 0) begin : g_first
                assign valid_in = in_valid;
                assign tag_in   = in_tag;
                assign rem_in   = '0;
                assign rad_in   = in_rad;
                assign root_in  = '0;
            end else begin : g_rest
                assign valid_in = valid_reg[g-1];
                assign tag_in   = tag_reg[g-1];
                assign rem_in   = rem_reg[g-1];
                assign rad_in   = rad_reg[g-1];
                assign root_in  = root_reg[g-1];
            end

            // trial subtrahend is 4*root + 1
            assign cur       = {rem_in, rad_in[RAD_W-1:RAD_W-2]};
            assign trial     = {2'b00, root_in, 2'b01};
            assign diff      = cur - trial;
            assign ge        = cur >= trial;
            assign rem_next  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
            assign rad_next  = {rad_in[RAD_W-3:0], 2'b00};
            assign root_next = {root_in[ROOT_W-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[g] <= valid_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    root_reg[g] <= root_next;
                    tag_reg[g]  <= tag_in;
                end
            end

            if (g < ROOT_W - 1) begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[g] <= rem_next;
                        rad_reg[g] <= rad_next;
                    end
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_tag   = tag_reg[ROOT_W-1];

endmodule

`default_nettype wire

[tb/sv/distance_constraint_projection_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// distance_constraint_projection_tb
// Streams directed and random joints through the projection block under
// bursty input and random output stall, predicts each corrected joint in
// exact integer math, and checks results in order. Steps break_ratio through
// several values, extremes included, between idle phases.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
    logic signed [31:0] p1 [3];
    logic signed [31:0] p2 [3];
    logic [23:0]        w1;
    logic [23:0]        w2;
    logic               m1;
    logic               m2;
    logic [30:0]        rest;
} joint_in_t;

typedef struct {
    logic signed [31:0] p1 [3];
    logic signed [31:0] p2 [3];
    logic [30:0]        rest;
    dcp_pkg::status_t   st;
} joint_out_t;

class projection_scoreboard;
    joint_out_t  pending [$];
    logic [9:0]  ratio;
    int          errors;

    function new();
        ratio  = dcp_pkg::RATIO_RESET;
        errors = 0;
    endfunction

    static function logic signed [31:0] clamp(logic signed [39:0] v);
        if (v > 40'sd2147483647)
            return 32'sh7fffffff;
        if (v < -40'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function void note_joint(joint_in_t j);
        joint_out_t         r;
        logic signed [33:0] d [3];
        logic [32:0]        mag [3];
        logic [67:0]        sq;
        logic [33:0]        len;
        logic [33:0]        lo, hi, mid;
        logic [24:0]        ws;
        logic [34:0]        errm;
        logic               err_neg;
        logic [127:0]       tm;
        logic [63:0]        c1u, c2u;
        logic signed [39:0] c1, c2, a1, a2;
        logic [47:0]        lhs, rhs;
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i]   = 34'(j.p2[i]) - 34'(j.p1[i]);
            mag[i] = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
            sq     = sq + 68'(mag[i]) * 68'(mag[i]);
            r.p1[i] = j.p1[i];
            r.p2[i] = j.p2[i];
        end
        lo = 0;
        hi = 34'h3_ffff_ffff;
        // floor sqrt by bisection over [0, 2^34)
        while (hi - lo > 1)
        begin
            mid = lo + (hi - lo) / 2;
            if (68'(mid) * 68'(mid) > sq)
                hi = mid;
            else
                lo = mid;
        end
        if (68'(hi) * 68'(hi) <= sq)
            lo = hi;
        len = lo;
        lhs = 48'(len) * 48'd256;
        rhs = 48'(j.rest) * 48'(ratio);
        ws  = 25'(j.w1) + 25'(j.w2);
        r.rest = (len == 0) ? j.rest : (len > 34'h7fffffff ? 31'h7fffffff : len[30:0]);
        if (len == 0)
            r.st = dcp_pkg::STATUS_ZERO_LEN;
        else if (lhs >= rhs)
            r.st = dcp_pkg::STATUS_CUT;
        else if (ws == 0)
            r.st = dcp_pkg::STATUS_ZERO_MASS;
        else
        begin
            r.st    = dcp_pkg::STATUS_APPLIED;
            err_neg = len < 34'(j.rest);
            errm    = err_neg ? 35'(j.rest) - 35'(len) : 35'(len) - 35'(j.rest);
            for (int i = 0; i < 3; i++)
            begin
                tm  = (128'(errm) * 128'(mag[i])) / 128'(len);
                c1u = 64'((tm * 128'(j.w1)) / 128'(ws));
                c2u = 64'((tm * 128'(j.w2)) / 128'(ws));
                c1  = 40'(c1u);
                c2  = 40'(c2u);
                if (err_neg != (d[i] < 0))
                begin
                    c1 = -c1;
                    c2 = -c2;
                end
                a1 = 40'(j.p1[i]);
                a2 = 40'(j.p2[i]);
                if (j.m1 && j.m2)
                begin
                    a1 = a1 + c1;
                    a2 = a2 - c2;
                end
                else if (j.m1)
                    a1 = a1 + 2 * c1;
                else if (j.m2)
                    a2 = a2 - 2 * c2;
                r.p1[i] = clamp(a1);
                r.p2[i] = clamp(a2);
            end
        end
        pending.push_back(r);
    endfunction

    function void check_joint(joint_out_t a);
        joint_out_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result, status %0d", $time, a.st);
            errors++;
            return;
        end
        e = pending.pop_front();
        for (int i = 0; i < 3; i++)
        begin
            if (a.p1[i] !== e.p1[i])
            begin
                $display("%0t: first[%0d] expected %h actual %h", $time, i, e.p1[i], a.p1[i]);
                errors++;
            end
            if (a.p2[i] !== e.p2[i])
            begin
                $display("%0t: second[%0d] expected %h actual %h", $time, i, e.p2[i], a.p2[i]);
                errors++;
            end
        end
        if (a.rest !== e.rest)
        begin
            $display("%0t: rest expected %h actual %h", $time, e.rest, a.rest);
            errors++;
        end
        if (a.st !== e.st)
        begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, a.st);
            errors++;
        end
    endfunction
endclass

module distance_constraint_projection_tb;

    localparam int LATENCY   = 106;
    localparam int MAX_CYCLE = 400000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [9:0]         cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] first_x = '0, first_y = '0, first_z = '0;
    logic signed [31:0] second_x = '0, second_y = '0, second_z = '0;
    logic [23:0]        first_inv_mass = '0, second_inv_mass = '0;
    logic               first_moving = 1'b0, second_moving = 1'b0;
    logic [30:0]        rest_length = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] new_first_x, new_first_y, new_first_z;
    logic signed [31:0] new_second_x, new_second_y, new_second_z;
    logic [30:0]        new_rest_length;
    logic [1:0]         status;

    projection_scoreboard board = new();
    int unsigned          cycle = 0;
    int unsigned          stall_mode = 0;

    distance_constraint_projection dut (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle >= MAX_CYCLE)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: stall pattern follows a randomly chosen mode
    always @(posedge clk)
    begin
        joint_out_t a;
        if (out_valid && !out_stall)
        begin
            a.p1[0] = new_first_x;
            a.p1[1] = new_first_y;
            a.p1[2] = new_first_z;
            a.p2[0] = new_second_x;
            a.p2[1] = new_second_y;
            a.p2[2] = new_second_z;
            a.rest  = new_rest_length;
            a.st    = dcp_pkg::status_t'(status);
            board.check_joint(a);
        end
        if (cycle % 300 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ((cycle % 16) < 6);
        endcase
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh7fffffff - $urandom_range(0, 3);
            2: return 32'sh80000000 + $urandom_range(0, 3);
            default: return $signed(32'($urandom_range(0, 32'h000fffff))) - 32'sh00080000;
        endcase
    endfunction

    function automatic joint_in_t rand_joint();
        joint_in_t j;
        logic signed [31:0] spread;
        spread = (32'sd1 << $urandom_range(0, 30)) - 1;
        for (int i = 0; i < 3; i++)
        begin
            j.p1[i] = rand_coord();
            if ($urandom_range(0, 3) != 0)
                j.p2[i] = j.p1[i] + ($signed(32'($urandom)) & spread) - (spread >>> 1);
            else
                j.p2[i] = rand_coord();
        end
        if ($urandom_range(0, 15) == 0)
            for (int i = 0; i < 3; i++)
                j.p2[i] = j.p1[i];
        case ($urandom_range(0, 7))
            0: j.w1 = 0;
            1: j.w1 = 24'hffffff;
            default: j.w1 = 24'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0: j.w2 = 0;
            1: j.w2 = 24'hffffff;
            default: j.w2 = 24'($urandom);
        endcase
        j.m1 = 1'($urandom);
        j.m2 = 1'($urandom);
        case ($urandom_range(0, 5))
            0: j.rest = 0;
            1: j.rest = 31'($urandom);
            default: j.rest = 31'(spread) - 31'($urandom_range(0, 32'(spread) >> 1));
        endcase
        return j;
    endfunction

    task automatic send_joint(joint_in_t j);
        in_valid        <= 1'b1;
        first_x         <= j.p1[0];
        first_y         <= j.p1[1];
        first_z         <= j.p1[2];
        second_x        <= j.p2[0];
        second_y        <= j.p2[1];
        second_z        <= j.p2[2];
        first_inv_mass  <= j.w1;
        second_inv_mass <= j.w2;
        first_moving    <= j.m1;
        second_moving   <= j.m2;
        rest_length     <= j.rest;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_joint(j);
    endtask

    task automatic idle_cycles(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_ratio(logic [9:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        board.ratio = v;
    endtask

    task automatic run_random(int n);
        int burst;
        while (n > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && n > 0)
            begin
                send_joint(rand_joint());
                burst--;
                n--;
            end
            idle_cycles($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12));
        end
    endtask

    function automatic joint_in_t make_joint(logic signed [31:0] ax, logic signed [31:0] bx,
                                             logic [23:0] w1, logic [23:0] w2,
                                             logic m1, logic m2, logic [30:0] rest);
        joint_in_t j;
        for (int i = 0; i < 3; i++)
        begin
            j.p1[i] = 0;
            j.p2[i] = 0;
        end
        j.p1[0] = ax;
        j.p2[0] = bx;
        j.p1[1] = 32'sh00010000;
        j.p2[1] = 32'sh00030000;
        j.w1 = w1;
        j.w2 = w2;
        j.m1 = m1;
        j.m2 = m2;
        j.rest = rest;
        return j;
    endfunction

    task automatic run_directed();
        joint_in_t j;
        // both moving, one moving each way, neither moving
        send_joint(make_joint(0, 32'sh00040000, 24'h010000, 24'h010000, 1, 1, 31'h00050000));
        send_joint(make_joint(0, 32'sh00040000, 24'h010000, 24'h020000, 1, 0, 31'h00050000));
        send_joint(make_joint(0, 32'sh00040000, 24'h030000, 24'h010000, 0, 1, 31'h00050000));
        send_joint(make_joint(0, 32'sh00040000, 24'h010000, 24'h010000, 0, 0, 31'h00050000));
        // equal x coordinates, then zero length
        send_joint(make_joint(32'sh00010000, 32'sh00010000, 24'h1, 24'h1, 1, 1, 31'h7fffffff));
        j = make_joint(0, 0, 24'hffffff, 24'hffffff, 1, 1, 0);
        j.p2[1] = 32'sh00010000;
        send_joint(j);
        // zero rest length always cuts
        send_joint(make_joint(0, 32'sh00000001, 24'h010000, 24'h010000, 1, 1, 0));
        // two joints stretched past the cut threshold
        send_joint(make_joint(0, 32'sh00040000, 24'h010000, 24'h010000, 1, 1, 31'h00019ffe));
        send_joint(make_joint(0, 32'sh00050000, 24'h010000, 24'h010000, 1, 1, 31'h00040000));
        // zero mass sum
        send_joint(make_joint(0, 32'sh00040000, 0, 0, 1, 1, 31'h00050000));
        // extremes of coordinates, masses and rest length
        send_joint(make_joint(32'sh80000000, 32'sh7fffffff, 24'hffffff, 0, 1, 1, 31'h7fffffff));
        send_joint(make_joint(32'sh7fffffff, 32'sh80000000, 0, 24'hffffff, 1, 1, 31'h7fffffff));
        for (int i = 0; i < 3; i++)
        begin
            j.p1[i] = 32'sh7fffffff;
            j.p2[i] = 32'sh80000000;
        end
        j.w1 = 24'hffffff;
        j.w2 = 24'h000001;
        j.m1 = 1;
        j.m2 = 0;
        j.rest = 31'h7fffffff;
        send_joint(j);
        j.m1 = 0;
        j.m2 = 1;
        j.w2 = 24'hffffff;
        send_joint(j);
        // positions pushed past full scale
        send_joint(make_joint(32'sh7fff0000, 32'sh7fff8000, 24'h010000, 24'h010000, 0, 1,
                              31'h7fff0000));
        send_joint(make_joint(32'sh80000000, 32'sh80010000, 24'h010000, 24'h010000, 1, 0,
                              31'h40000000));
    endtask

    initial
    begin
        logic [9:0] ratios [5];
        ratios = '{10'd256, 10'd1023, 10'd0, 10'd1, 10'd512};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(150);
        // sender holds off until the pipe is empty
        drain();
        for (int p = 0; p < 5; p++)
        begin
            write_ratio(ratios[p]);
            if (p == 0)
                run_directed();
            run_random(p == 4 ? 100 : 110);
            drain();
        end
        write_ratio(10'(dcp_pkg::RATIO_RESET));
        run_random(40);
        drain();
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
